// ----- sv/utf8v_pkg.sv -----
`default_nettype none

package utf8v_pkg;

    // Sequence length codes: total length minus one
    localparam logic [1:0] LEN_1 = 2'd0;
    localparam logic [1:0] LEN_2 = 2'd1;
    localparam logic [1:0] LEN_3 = 2'd2;
    localparam logic [1:0] LEN_4 = 2'd3;

    // Lead and continuation byte patterns
    localparam logic [2:0] LEAD_2_TAG  = 3'b110;
    localparam logic [3:0] LEAD_3_TAG  = 4'b1110;
    localparam logic [4:0] LEAD_4_TAG  = 5'b11110;
    localparam logic [1:0] CONT_TAG    = 2'b10;

    // Code point limits
    localparam logic [20:0] CP_MIN_2     = 21'h000080;
    localparam logic [20:0] CP_MIN_3     = 21'h000800;
    localparam logic [20:0] CP_MIN_4     = 21'h010000;
    localparam logic [20:0] CP_MAX       = 21'h10FFFF;
    localparam logic [20:0] CP_SURR_LO   = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI   = 21'h00DFFF;
    localparam logic [20:0] CP_CTRL_MAX  = 21'h00001F;
    localparam logic [20:0] CP_DEL       = 21'h00007F;
    localparam logic [20:0] CP_TAB       = 21'h000009;
    localparam logic [20:0] CP_LF        = 21'h00000A;
    localparam logic [20:0] CP_CR        = 21'h00000D;
    localparam logic [7:0]  BYTE_LF      = 8'h0A;

    // One input item as it travels through the pipe
    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       last;
    } item_t;

    // Outcome of a code point check
    typedef struct packed {
        logic ok;
        logic cr;
    } cp_check_t;

    // Check a complete code point for form and for allowed controls
    function automatic cp_check_t check_cp(input logic [20:0] cp,
                                           input logic [1:0]  len_code,
                                           input logic [1:0]  kind);
        cp_check_t res;
        logic      bad_form;
        logic      is_ctrl;
        logic      multi;
        res.ok   = 1'b1;
        res.cr   = 1'b0;
        multi    = kind[0];
        bad_form = ((len_code == LEN_2) && (cp < CP_MIN_2)) ||
                   ((len_code == LEN_3) &&
                    ((cp < CP_MIN_3) || ((cp >= CP_SURR_LO) && (cp <= CP_SURR_HI)))) ||
                   ((len_code == LEN_4) && ((cp < CP_MIN_4) || (cp > CP_MAX)));
        is_ctrl  = (cp <= CP_CTRL_MAX) || (cp == CP_DEL);
        if (bad_form)
        begin
            res.ok = 1'b0;
        end
        else if (is_ctrl)
        begin
            if (cp == CP_TAB)
            begin
                res.ok = 1'b1;
            end
            else if (!multi)
            begin
                res.ok = 1'b0;
            end
            else if (cp == CP_LF)
            begin
                res.ok = 1'b1;
            end
            else if (cp == CP_CR)
            begin
                res.cr = 1'b1;
            end
            else
            begin
                res.ok = 1'b0;
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- sv/utf8v_in_stage.sv -----
`default_nettype none

module utf8v_in_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire utf8v_pkg::item_t in_item,
    input  wire logic             adv,
    output logic                  s1_valid,
    output utf8v_pkg::item_t      s1_item
);

    logic             valid_reg;
    logic             valid_next;
    utf8v_pkg::item_t item_reg;
    logic             load;

    // Take a new item whenever the held one leaves or the stage is empty
    assign in_stall   = valid_reg && !adv;
    assign load       = in_valid && !in_stall;
    assign valid_next = load ? 1'b1 : (adv ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload until the next item is taken
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_item  = item_reg;

endmodule

`default_nettype wire

// ----- sv/utf8v_decode.sv -----
`default_nettype none

module utf8v_decode (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fire,
    input  wire utf8v_pkg::item_t item,
    output logic                  verdict
);

    logic        err_reg;
    logic        err_next;
    logic [1:0]  rem_reg;
    logic [1:0]  rem_next;
    logic [1:0]  len_reg;
    logic [1:0]  len_next;
    logic [20:0] cp_reg;
    logic [20:0] cp_next;
    logic        crp_reg;
    logic        crp_next;

    logic                  chk_en;
    logic [20:0]           chk_cp;
    logic [1:0]            chk_len;
    utf8v_pkg::cp_check_t  chk;
    logic                  cr_fail;
    logic [7:0]            b;

    assign b = item.data;

    // Decode one byte against the current sequence state
    always_comb
    begin
        err_next = err_reg;
        rem_next = rem_reg;
        len_next = len_reg;
        cp_next  = cp_reg;
        crp_next = crp_reg;
        chk_en   = 1'b0;
        chk_cp   = {13'd0, b};
        chk_len  = utf8v_pkg::LEN_1;
        chk      = '0;
        cr_fail  = 1'b0;
        if (!err_reg)
        begin
            if (rem_reg == 2'd0)
            begin
                // Drop the pending CR; anything but LF after it is an error
                if (crp_reg)
                begin
                    crp_next = 1'b0;
                    cr_fail  = (b != utf8v_pkg::BYTE_LF);
                end
                if (cr_fail)
                begin
                    err_next = 1'b1;
                end
                else if (!b[7])
                begin
                    chk_en = 1'b1;
                end
                else if (b[7:5] == utf8v_pkg::LEAD_2_TAG)
                begin
                    cp_next  = {16'd0, b[4:0]};
                    len_next = utf8v_pkg::LEN_2;
                    rem_next = 2'd1;
                end
                else if (b[7:4] == utf8v_pkg::LEAD_3_TAG)
                begin
                    cp_next  = {17'd0, b[3:0]};
                    len_next = utf8v_pkg::LEN_3;
                    rem_next = 2'd2;
                end
                else if (b[7:3] == utf8v_pkg::LEAD_4_TAG)
                begin
                    cp_next  = {18'd0, b[2:0]};
                    len_next = utf8v_pkg::LEN_4;
                    rem_next = 2'd3;
                end
                else
                begin
                    err_next = 1'b1;
                end
            end
            else if (b[7:6] != utf8v_pkg::CONT_TAG)
            begin
                err_next = 1'b1;
            end
            else
            begin
                // Shift in six payload bits; check when the sequence completes
                cp_next  = {cp_reg[14:0], b[5:0]};
                rem_next = rem_reg - 2'd1;
                if (rem_reg == 2'd1)
                begin
                    chk_en  = 1'b1;
                    chk_cp  = {cp_reg[14:0], b[5:0]};
                    chk_len = len_reg;
                end
            end
            if (chk_en)
            begin
                chk = utf8v_pkg::check_cp(chk_cp, chk_len, item.kind);
                if (!chk.ok)
                begin
                    err_next = 1'b1;
                end
                if (chk.cr)
                begin
                    crp_next = 1'b1;
                end
            end
        end
    end

    assign verdict = !err_next && (rem_next == 2'd0) && !crp_next;

    // Advance the state; clear it after the last byte of a string
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg <= 1'b0;
            rem_reg <= 2'd0;
            len_reg <= 2'd0;
            cp_reg  <= 21'd0;
            crp_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (item.last)
            begin
                err_reg <= 1'b0;
                rem_reg <= 2'd0;
                len_reg <= 2'd0;
                cp_reg  <= 21'd0;
                crp_reg <= 1'b0;
            end
            else
            begin
                err_reg <= err_next;
                rem_reg <= rem_next;
                len_reg <= len_next;
                cp_reg  <= cp_next;
                crp_reg <= crp_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/utf8v_out_stage.sv -----
`default_nettype none

module utf8v_out_stage (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic load,
    input  wire logic verdict,
    output logic      free,
    output logic      out_valid,
    input  wire logic out_stall,
    output logic      content_valid
);

    logic valid_reg;
    logic valid_next;
    logic data_reg;

    // Room for a new result when empty or when the held one is taken now
    assign free       = !valid_reg || !out_stall;
    assign valid_next = load ? 1'b1 : (free ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the verdict while stalled
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= verdict;
        end
    end

    assign out_valid     = valid_reg;
    assign content_valid = data_reg;

endmodule

`default_nettype wire

// ----- sv/utf8_string_content_validator.sv -----
`default_nettype none

// UTF-8 string content validator. Bytes of a string enter one per cycle when
// not stalled, on the input channel with a kind code and a last-byte mark; the
// block decodes UTF-8 on the fly, rejecting malformed, overlong, surrogate and
// out-of-range sequences and the control characters that the kind does not
// allow (single-line kinds 0 and 2 allow only tab; multi-line kinds 1 and 3
// also allow LF, and CR only when LF follows). Only the last byte of a string
// produces an item on the output channel, carrying content_valid; other bytes
// produce none. Throughput is one byte per cycle while the input is not
// stalled, set by the single decode stage that updates the sequence state as
// each byte moves on; the verdict of a string is loaded into the output
// register as its last byte leaves the input register, and is offered on the
// output from then on. The input stalls only while a verdict is held back by a
// stalled output and another verdict is waiting behind it.
module utf8_string_content_validator (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic [1:0] string_kind,
    input  wire logic       last_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            content_valid
);

    utf8v_pkg::item_t in_item;
    utf8v_pkg::item_t s1_item;
    logic             s1_valid;
    logic             adv;
    logic             out_free;
    logic             verdict;

    assign in_item.data = data_byte;
    assign in_item.kind = string_kind;
    assign in_item.last = last_byte;

    // Move the held byte on unless its verdict has nowhere to go
    assign adv = s1_valid && (!s1_item.last || out_free);

    utf8v_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .adv      (adv),
        .s1_valid (s1_valid),
        .s1_item  (s1_item)
    );

    utf8v_decode u_dec (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (adv),
        .item    (s1_item),
        .verdict (verdict)
    );

    utf8v_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (adv && s1_item.last),
        .verdict       (verdict),
        .free          (out_free),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .content_valid (content_valid)
    );

endmodule

`default_nettype wire

// ----- dv/utf8_string_content_validator_test.sv -----
`timescale 1ns / 1ps

module utf8_string_content_validator_test;

    typedef logic [7:0] byte_q_t[$];

    typedef enum int
    {
        IDLE_MIXED,
        IDLE_NONE,
        IDLE_OUT_HEAVY
    } idle_mode_t;

    localparam logic [1:0] KIND_LINE     = 2'd0;
    localparam logic [1:0] KIND_TEXT     = 2'd1;
    localparam logic [1:0] KIND_LINE_ALT = 2'd2;
    localparam logic [1:0] KIND_TEXT_ALT = 2'd3;

    localparam logic [7:0] BYTE_TAB = 8'h09;
    localparam logic [7:0] BYTE_CR  = 8'h0D;

    localparam int WAIT_MAX   = 16;
    localparam int HANG_LIMIT = 2000;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] data_byte;
    logic [1:0] string_kind;
    logic       last_byte;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       content_valid;

    // decoder state of the string being predicted
    logic        str_broken = 1'b0;
    logic [1:0]  cont_left  = 2'd0;
    logic [1:0]  seq_len    = 2'd0;
    logic [20:0] cp_acc     = 21'd0;
    logic        cr_wait    = 1'b0;

    logic       verdicts[$];
    logic       want_verdict;
    idle_mode_t idle_mode     = IDLE_MIXED;
    int         hold_left     = 0;
    int         quiet_cycles  = 0;
    int         failures      = 0;
    int         bytes_sent    = 0;
    int         strings_sent  = 0;
    int         good_strings  = 0;
    int         verdicts_seen = 0;

    utf8_string_content_validator dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .string_kind   (string_kind),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .content_valid (content_valid)
    );

    always #1 clk = ~clk;

    // Append one byte at the tail of a byte queue
    function automatic void add_byte(ref byte_q_t s, input logic [7:0] b);
        s.insert(s.size(), b);
    endfunction

    // Judge one complete code point; flag a CR that must be closed by LF
    function automatic logic codepoint_allowed(input logic [20:0] cp,
                                               input logic [1:0]  len,
                                               input logic [1:0]  kind,
                                               output logic       cr_hit);
        cr_hit = 1'b0;
        if ((len == utf8v_pkg::LEN_2) && (cp < utf8v_pkg::CP_MIN_2))
            return 1'b0;
        if ((len == utf8v_pkg::LEN_3) &&
            ((cp < utf8v_pkg::CP_MIN_3) ||
             ((cp >= utf8v_pkg::CP_SURR_LO) && (cp <= utf8v_pkg::CP_SURR_HI))))
            return 1'b0;
        if ((len == utf8v_pkg::LEN_4) &&
            ((cp < utf8v_pkg::CP_MIN_4) || (cp > utf8v_pkg::CP_MAX)))
            return 1'b0;
        if ((cp <= utf8v_pkg::CP_CTRL_MAX) || (cp == utf8v_pkg::CP_DEL))
        begin
            if (cp == utf8v_pkg::CP_TAB)
                return 1'b1;
            if (!kind[0])
                return 1'b0;
            if (cp == utf8v_pkg::CP_LF)
                return 1'b1;
            if (cp == utf8v_pkg::CP_CR)
            begin
                cr_hit = 1'b1;
                return 1'b1;
            end
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Advance the decoder by one accepted byte; queue the verdict on the last one
    task automatic predict_byte(input logic [7:0] b, input logic [1:0] k, input logic l);
        logic cr_hit;
        logic verdict;
        if (!str_broken)
        begin
            if (cont_left == 2'd0)
            begin
                // a pending CR must be followed by LF
                if (cr_wait)
                begin
                    cr_wait = 1'b0;
                    if (b != utf8v_pkg::BYTE_LF)
                        str_broken = 1'b1;
                end
                if (!str_broken)
                begin
                    if (!b[7])
                    begin
                        if (!codepoint_allowed({13'd0, b}, utf8v_pkg::LEN_1, k, cr_hit))
                            str_broken = 1'b1;
                        else if (cr_hit)
                            cr_wait = 1'b1;
                    end
                    else if (b[7:5] == utf8v_pkg::LEAD_2_TAG)
                    begin
                        cp_acc    = {16'd0, b[4:0]};
                        seq_len   = utf8v_pkg::LEN_2;
                        cont_left = 2'd1;
                    end
                    else if (b[7:4] == utf8v_pkg::LEAD_3_TAG)
                    begin
                        cp_acc    = {17'd0, b[3:0]};
                        seq_len   = utf8v_pkg::LEN_3;
                        cont_left = 2'd2;
                    end
                    else if (b[7:3] == utf8v_pkg::LEAD_4_TAG)
                    begin
                        cp_acc    = {18'd0, b[2:0]};
                        seq_len   = utf8v_pkg::LEN_4;
                        cont_left = 2'd3;
                    end
                    else
                    begin
                        str_broken = 1'b1;
                    end
                end
            end
            else if (b[7:6] != utf8v_pkg::CONT_TAG)
            begin
                str_broken = 1'b1;
            end
            else
            begin
                cp_acc    = {cp_acc[14:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0)
                begin
                    if (!codepoint_allowed(cp_acc, seq_len, k, cr_hit))
                        str_broken = 1'b1;
                    else if (cr_hit)
                        cr_wait = 1'b1;
                end
            end
        end
        if (l)
        begin
            verdict = !str_broken && (cont_left == 2'd0) && !cr_wait;
            verdicts.insert(verdicts.size(), verdict);
            strings_sent++;
            if (verdict)
                good_strings++;
            str_broken = 1'b0;
            cont_left  = 2'd0;
            seq_len    = 2'd0;
            cp_acc     = 21'd0;
            cr_wait    = 1'b0;
        end
    endtask

    // Draw the idle cycles for one item on either side
    function automatic int draw_wait(input bit for_output);
        if (idle_mode == IDLE_NONE)
            return 0;
        if (idle_mode == IDLE_OUT_HEAVY)
            return for_output ? int'($urandom_range(8, WAIT_MAX)) : 0;
        if ($urandom_range(0, 1) == 0)
            return 0;
        return int'($urandom_range(0, WAIT_MAX));
    endfunction

    // Present one byte, hold it until taken, then predict
    task automatic send_byte(input logic [7:0] b, input logic [1:0] k, input logic l);
        int gap;
        gap = draw_wait(1'b0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        string_kind <= k;
        last_byte   <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_byte(b, k, l);
        bytes_sent++;
    endtask

    // Send a whole string; with jitter the kind may change from byte to byte
    task automatic send_string(input byte_q_t s, input logic [1:0] k, input bit jitter);
        logic [1:0] kk;
        foreach (s[i])
        begin
            kk = (jitter && ($urandom_range(0, 3) == 0)) ? 2'($urandom_range(0, 3)) : k;
            send_byte(s[i], kk, i == s.size() - 1);
        end
    endtask

    // Append a code point in UTF-8; a nonzero length forces that many bytes
    function automatic void encode_cp(ref byte_q_t s, input logic [20:0] cp, input int n);
        int len;
        len = n;
        if (len == 0)
            len = (cp < utf8v_pkg::CP_MIN_2) ? 1 :
                  (cp < utf8v_pkg::CP_MIN_3) ? 2 :
                  (cp < utf8v_pkg::CP_MIN_4) ? 3 : 4;
        case (len)
            1:
            begin
                add_byte(s, cp[7:0]);
            end
            2:
            begin
                add_byte(s, {utf8v_pkg::LEAD_2_TAG, cp[10:6]});
                add_byte(s, {utf8v_pkg::CONT_TAG, cp[5:0]});
            end
            3:
            begin
                add_byte(s, {utf8v_pkg::LEAD_3_TAG, cp[15:12]});
                add_byte(s, {utf8v_pkg::CONT_TAG, cp[11:6]});
                add_byte(s, {utf8v_pkg::CONT_TAG, cp[5:0]});
            end
            default:
            begin
                add_byte(s, {utf8v_pkg::LEAD_4_TAG, cp[20:18]});
                add_byte(s, {utf8v_pkg::CONT_TAG, cp[17:12]});
                add_byte(s, {utf8v_pkg::CONT_TAG, cp[11:6]});
                add_byte(s, {utf8v_pkg::CONT_TAG, cp[5:0]});
            end
        endcase
    endfunction

    // Build a mostly well-formed string, with one flaw in about a quarter of them
    task automatic build_text(ref byte_q_t s, input logic [1:0] k);
        int          n_cp;
        int          flaw_at;
        int          len;
        int          keep;
        logic [20:0] cp;
        byte_q_t     tmp;
        s.delete();
        n_cp    = $urandom_range(1, 10);
        flaw_at = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, n_cp - 1)) : -1;
        for (int i = 0; i < n_cp; i++)
        begin
            if (i != flaw_at)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: encode_cp(s, 21'($urandom_range(8'h20, 8'h7E)), 0);
                    4:
                    begin
                        // allowed controls for the kind
                        if (!k[0])
                            add_byte(s, BYTE_TAB);
                        else
                        begin
                            case ($urandom_range(0, 2))
                                0: add_byte(s, BYTE_TAB);
                                1: add_byte(s, utf8v_pkg::BYTE_LF);
                                default:
                                begin
                                    add_byte(s, BYTE_CR);
                                    add_byte(s, utf8v_pkg::BYTE_LF);
                                end
                            endcase
                        end
                    end
                    5, 6:
                    begin
                        cp = 21'($urandom_range(utf8v_pkg::CP_MIN_2,
                                                utf8v_pkg::CP_MIN_3 - 1));
                        encode_cp(s, cp, 0);
                    end
                    7:
                    begin
                        if ($urandom_range(0, 1) == 0)
                            cp = 21'($urandom_range(utf8v_pkg::CP_MIN_3,
                                                    utf8v_pkg::CP_SURR_LO - 1));
                        else
                            cp = 21'($urandom_range(utf8v_pkg::CP_SURR_HI + 1,
                                                    utf8v_pkg::CP_MIN_4 - 1));
                        encode_cp(s, cp, 0);
                    end
                    8:
                    begin
                        cp = 21'($urandom_range(utf8v_pkg::CP_MIN_4, utf8v_pkg::CP_MAX));
                        encode_cp(s, cp, 0);
                    end
                    default:
                    begin
                        // boundaries of each length and around the surrogates
                        case ($urandom_range(0, 7))
                            0: cp = utf8v_pkg::CP_MIN_2;
                            1: cp = utf8v_pkg::CP_MIN_3 - 21'd1;
                            2: cp = utf8v_pkg::CP_MIN_3;
                            3: cp = utf8v_pkg::CP_SURR_LO - 21'd1;
                            4: cp = utf8v_pkg::CP_SURR_HI + 21'd1;
                            5: cp = utf8v_pkg::CP_MIN_4 - 21'd1;
                            6: cp = utf8v_pkg::CP_MIN_4;
                            default: cp = utf8v_pkg::CP_MAX;
                        endcase
                        encode_cp(s, cp, 0);
                    end
                endcase
            end
            else
            begin
                case ($urandom_range(0, 8))
                    0: add_byte(s, 8'($urandom_range(0, 255)));
                    1:
                    begin
                        if ($urandom_range(0, 4) == 0)
                            add_byte(s, utf8v_pkg::CP_DEL[7:0]);
                        else
                            add_byte(s, 8'($urandom_range(0, 31)));
                    end
                    2:
                    begin
                        // overlong form of a shorter code point
                        len = $urandom_range(2, 4);
                        if (len == 2)
                            cp = 21'($urandom_range(0, utf8v_pkg::CP_MIN_2 - 1));
                        else if (len == 3)
                            cp = 21'($urandom_range(0, utf8v_pkg::CP_MIN_3 - 1));
                        else
                            cp = 21'($urandom_range(0, utf8v_pkg::CP_MIN_4 - 1));
                        encode_cp(s, cp, len);
                    end
                    3:
                    begin
                        cp = 21'($urandom_range(utf8v_pkg::CP_SURR_LO,
                                                utf8v_pkg::CP_SURR_HI));
                        encode_cp(s, cp, 3);
                    end
                    4:
                    begin
                        cp = 21'($urandom_range(utf8v_pkg::CP_MAX + 1, 21'h1FFFFF));
                        encode_cp(s, cp, 4);
                    end
                    5:
                    begin
                        // drop the tail of a multi-byte sequence
                        tmp.delete();
                        cp = 21'($urandom_range(utf8v_pkg::CP_MIN_2, utf8v_pkg::CP_MAX));
                        encode_cp(tmp, cp, 0);
                        keep = $urandom_range(1, tmp.size() - 1);
                        for (int j = 0; j < keep; j++)
                            add_byte(s, tmp[j]);
                    end
                    6:
                    begin
                        add_byte(s, BYTE_CR);
                        add_byte(s, 8'($urandom_range(0, 255)));
                    end
                    7: add_byte(s, 8'($urandom_range(8'h80, 8'hBF)));
                    default: add_byte(s, 8'($urandom_range(8'hF8, 8'hFF)));
                endcase
            end
        end
    endtask

    // Random strings until the given number of bytes has gone in
    task automatic run_random(input int n_bytes);
        byte_q_t    s;
        logic [1:0] k;
        bit         jitter;
        int         stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            k      = 2'($urandom_range(0, 3));
            jitter = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                // raw noise
                s.delete();
                repeat ($urandom_range(1, 8))
                    add_byte(s, 8'($urandom_range(0, 255)));
            end
            else
            begin
                build_text(s, k);
            end
            send_string(s, k, jitter);
        end
    endtask

    task automatic test_edge_bytes();
        byte_q_t s;
        s = '{8'h00};
        send_string(s, KIND_TEXT, 1'b0);
        s = '{8'hFF};
        send_string(s, KIND_LINE_ALT, 1'b0);
    endtask

    task automatic test_control_rules();
        byte_q_t s;
        s = '{BYTE_TAB};
        send_string(s, KIND_LINE, 1'b0);
        s = '{utf8v_pkg::BYTE_LF};
        send_string(s, KIND_LINE_ALT, 1'b0);
        s = '{BYTE_CR, utf8v_pkg::BYTE_LF};
        send_string(s, KIND_TEXT_ALT, 1'b0);
        // CR as the final code point
        s = '{BYTE_CR};
        send_string(s, KIND_TEXT, 1'b0);
        // CR followed by something other than LF
        s = '{BYTE_CR, 8'h78};
        send_string(s, KIND_TEXT, 1'b0);
        // kind switches to single-line on the LF that closes the CR
        send_byte(BYTE_CR, KIND_TEXT, 1'b0);
        send_byte(utf8v_pkg::BYTE_LF, KIND_LINE, 1'b1);
    endtask

    task automatic test_multibyte_forms();
        byte_q_t s;
        s = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_string(s, KIND_LINE, 1'b0);
        s = '{8'hC1, 8'hBF};
        send_string(s, KIND_TEXT, 1'b0);
        s = '{8'hED, 8'hA0, 8'h80};
        send_string(s, KIND_LINE_ALT, 1'b0);
        s = '{8'hF4, 8'h90, 8'h80, 8'h80};
        send_string(s, KIND_TEXT_ALT, 1'b0);
        s = '{8'hE2};
        send_string(s, KIND_LINE, 1'b0);
        s = '{8'hC2, 8'h41};
        send_string(s, KIND_TEXT, 1'b0);
    endtask

    task automatic test_random_text();
        idle_mode = IDLE_MIXED;
        run_random(800);
    endtask

    task automatic test_back_to_back();
        idle_mode = IDLE_NONE;
        run_random(250);
    endtask

    task automatic test_output_backpressure();
        idle_mode = IDLE_OUT_HEAVY;
        run_random(250);
    endtask

    // Take verdicts, compare against the oldest prediction, then draw the next stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                verdicts_seen++;
                if (verdicts.size() == 0)
                begin
                    $error("content_valid: expected none pending, actual %0b", content_valid);
                    failures++;
                end
                else
                begin
                    want_verdict = verdicts.pop_front();
                    if (content_valid !== want_verdict)
                    begin
                        $error("content_valid: expected %0b, actual %0b",
                               want_verdict, content_valid);
                        failures++;
                    end
                end
                hold_left = draw_wait(1'b1);
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Stop a hung run: count cycles with no item moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("timeout after %0d idle cycles", quiet_cycles);
            $display("utf8_string_content_validator: mismatch");
            $finish;
        end
    end

    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        data_byte   <= 8'd0;
        string_kind <= KIND_LINE;
        last_byte   <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_bytes();
        test_control_rules();
        test_multibyte_forms();
        test_random_text();
        test_back_to_back();
        test_output_backpressure();
        in_valid <= 1'b0;

        // drain outstanding verdicts, then allow for the pipeline depth
        while (verdicts.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("sent %0d bytes in %0d strings (%0d expected valid), checked %0d verdicts",
                 bytes_sent, strings_sent, good_strings, verdicts_seen);
        if (failures == 0)
            $display("utf8_string_content_validator: match");
        else
            $display("utf8_string_content_validator: mismatch");
        $finish;
    end

endmodule

// ----- utf8_string_content_validator.f -----
sv/utf8v_pkg.sv
sv/utf8v_in_stage.sv
sv/utf8v_decode.sv
sv/utf8v_out_stage.sv
sv/utf8_string_content_validator.sv
dv/utf8_string_content_validator_test.sv
